/* sv/hmlp_pkg.sv */
package hmlp_pkg;

	// record kinds carried on m_tuser
	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_MSG_DONE = 2'd1,
		KIND_MASK     = 2'd2,
		KIND_UNDEF    = 2'd3
	} kind_t;

	// line parsing phase, one-hot
	typedef enum logic [6:0] {
		PH_PREFIX = 7'b0000001,
		PH_TYPE   = 7'b0000010,
		PH_LEN    = 7'b0000100,
		PH_PAY    = 7'b0001000,
		PH_CRC    = 7'b0010000,
		PH_MASK   = 7'b0100000,
		PH_SKIP   = 7'b1000000
	} phase_t;

	localparam logic [7:0] CH_M  = 8'h6d;
	localparam logic [7:0] CH_E  = 8'h65;
	localparam logic [7:0] CH_A  = 8'h61;
	localparam logic [7:0] CH_S  = 8'h73;
	localparam logic [7:0] CH_K  = 8'h6b;
	localparam logic [7:0] CH_EQ = 8'h3d;

	localparam int unsigned PREFIX_LAST = 4;
	localparam int unsigned WORD_DIGITS = 8;

	// {valid, nibble} for one ascii character
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

/* sv/hex_message_line_parser.sv */
// hex message line parser
// slave channel (s_*): one ascii character per beat in s_tdata, s_tlast marks
// the last character of a line
// master channel (m_*): at most one record per input beat; m_tuser holds the
// record kind (payload byte, message complete, mask complete, undefined line),
// m_tdata holds the decoded type, length, byte index, byte value, crc and mask
// fields, zero where the kind does not use them
// "mess=" lines give one payload record per decoded byte and a message record
// after the eighth crc digit; "mask=" lines give a mask record after eight hex
// digits; anything else, a bad digit or an early line end gives one undefined
// record, and the rest of the line is skipped
// a record is registered and appears on m_* in the cycle after the beat that caused it
// throughput: one character per cycle while s_tready is high; the parse is a single combinational
// step from the line state registers into the output register
// when the receiver stalls, the output register holds its record and s_tready
// drops only while that register is full and m_tready is low
// reset: returns to the start of a line with no record pending
module hex_message_line_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code[7:0]
	input  logic        s_tlast,   // line_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // msg_type, msg_length, byte_index, byte_value,
	                               // crc_value, mask_value
	output logic [1:0]  m_tuser    // kind
);

	// line state
	hmlp_pkg::phase_t phase_q, nxt_phase;
	logic [2:0]  prefix_pos_q, nxt_prefix_pos;
	logic        prefix_is_mask_q, nxt_prefix_is_mask;
	logic [3:0]  high_nibble_q, nxt_high_nibble;
	logic [7:0]  type_q, nxt_type;
	logic [7:0]  length_q, nxt_length;
	logic [7:0]  bytes_done_q, nxt_bytes_done;
	logic [31:0] word_q, nxt_word;
	logic [3:0]  digit_count_q, nxt_digit_count;

	// record produced by this beat
	logic              res_vld;
	hmlp_pkg::kind_t   res_kind;
	logic [7:0]        res_type, res_length, res_index, res_value;
	logic [31:0]       res_crc, res_mask;

	// output register
	logic              m_tvalid_q;
	hmlp_pkg::kind_t   m_kind_q;
	logic [95:0]       m_data_q;

	logic        in_acc;
	logic [4:0]  hex;
	logic        is_hex;
	logic [3:0]  nib;
	logic        pfx_ok;
	logic [7:0]  byte_dec;

	assign s_tready = !m_tvalid_q || m_tready;
	assign in_acc   = s_tvalid && s_tready;
	assign hex      = hmlp_pkg::hex_decode(s_tdata);
	assign is_hex   = hex[4];
	assign nib      = hex[3:0];
	assign byte_dec = {high_nibble_q, nib};

	always_comb begin
		nxt_phase          = phase_q;
		nxt_prefix_pos     = prefix_pos_q;
		nxt_prefix_is_mask = prefix_is_mask_q;
		nxt_high_nibble    = high_nibble_q;
		nxt_type           = type_q;
		nxt_length         = length_q;
		nxt_bytes_done     = bytes_done_q;
		nxt_word           = word_q;
		nxt_digit_count    = digit_count_q;
		res_vld            = 1'b0;
		res_kind           = hmlp_pkg::KIND_UNDEF;
		res_type           = 8'd0;
		res_length         = 8'd0;
		res_index          = 8'd0;
		res_value          = 8'd0;
		res_crc            = 32'd0;
		res_mask           = 32'd0;
		pfx_ok             = 1'b0;

		case (phase_q)
			hmlp_pkg::PH_PREFIX: begin
				case (prefix_pos_q)
					3'd0: pfx_ok = (s_tdata == hmlp_pkg::CH_M);
					3'd1: begin
						if (s_tdata == hmlp_pkg::CH_E) begin
							pfx_ok             = 1'b1;
							nxt_prefix_is_mask = 1'b0;
						end else if (s_tdata == hmlp_pkg::CH_A) begin
							pfx_ok             = 1'b1;
							nxt_prefix_is_mask = 1'b1;
						end
					end
					3'd2: pfx_ok = (s_tdata == hmlp_pkg::CH_S);
					3'd3: pfx_ok = (s_tdata == (prefix_is_mask_q ? hmlp_pkg::CH_K
					                                             : hmlp_pkg::CH_S));
					3'd4: pfx_ok = (s_tdata == hmlp_pkg::CH_EQ);
					default: pfx_ok = 1'b0;
				endcase
				if (pfx_ok) begin
					nxt_prefix_pos = prefix_pos_q + 3'd1;
					if (prefix_pos_q == 3'(hmlp_pkg::PREFIX_LAST)) begin
						nxt_phase       = nxt_prefix_is_mask ? hmlp_pkg::PH_MASK
						                                     : hmlp_pkg::PH_TYPE;
						nxt_digit_count = 4'd0;
						nxt_word        = 32'd0;
					end
				end else begin
					res_vld   = 1'b1;
					nxt_phase = hmlp_pkg::PH_SKIP;
				end
			end
			hmlp_pkg::PH_TYPE, hmlp_pkg::PH_LEN, hmlp_pkg::PH_PAY,
			hmlp_pkg::PH_CRC, hmlp_pkg::PH_MASK: begin
				if (!is_hex) begin
					res_vld   = 1'b1;
					nxt_phase = hmlp_pkg::PH_SKIP;
				end else if (phase_q == hmlp_pkg::PH_CRC || phase_q == hmlp_pkg::PH_MASK) begin
					// 32-bit word, most significant digit first
					nxt_word        = {word_q[27:0], nib};
					nxt_digit_count = digit_count_q + 4'd1;
					if (digit_count_q == 4'(hmlp_pkg::WORD_DIGITS - 1)) begin
						res_vld   = 1'b1;
						nxt_phase = hmlp_pkg::PH_SKIP;
						if (phase_q == hmlp_pkg::PH_CRC) begin
							res_kind   = hmlp_pkg::KIND_MSG_DONE;
							res_type   = type_q;
							res_length = length_q;
							res_crc    = nxt_word;
						end else begin
							res_kind = hmlp_pkg::KIND_MASK;
							res_mask = nxt_word;
						end
					end
				end else if (digit_count_q == 4'd0) begin
					nxt_high_nibble = nib;
					nxt_digit_count = 4'd1;
				end else begin
					nxt_digit_count = 4'd0;
					if (phase_q == hmlp_pkg::PH_TYPE) begin
						nxt_type  = byte_dec;
						nxt_phase = hmlp_pkg::PH_LEN;
					end else if (phase_q == hmlp_pkg::PH_LEN) begin
						nxt_length     = byte_dec;
						nxt_bytes_done = 8'd0;
						nxt_word       = 32'd0;
						// zero length goes straight to the crc digits
						nxt_phase      = (byte_dec != 8'd0) ? hmlp_pkg::PH_PAY
						                                    : hmlp_pkg::PH_CRC;
					end else begin
						res_vld        = 1'b1;
						res_kind       = hmlp_pkg::KIND_PAYLOAD;
						res_type       = type_q;
						res_length     = length_q;
						res_index      = bytes_done_q;
						res_value      = byte_dec;
						nxt_bytes_done = bytes_done_q + 8'd1;
						if (nxt_bytes_done == length_q) begin
							nxt_phase = hmlp_pkg::PH_CRC;
							nxt_word  = 32'd0;
						end
					end
				end
			end
			default: begin
				// skipping the rest of the line
			end
		endcase

		// line end: an unfinished line becomes an undefined record, which
		// replaces a payload record from the same beat
		if (s_tlast) begin
			if (nxt_phase != hmlp_pkg::PH_SKIP) begin
				res_vld    = 1'b1;
				res_kind   = hmlp_pkg::KIND_UNDEF;
				res_type   = 8'd0;
				res_length = 8'd0;
				res_index  = 8'd0;
				res_value  = 8'd0;
				res_crc    = 32'd0;
				res_mask   = 32'd0;
			end
			nxt_phase          = hmlp_pkg::PH_PREFIX;
			nxt_prefix_pos     = 3'd0;
			nxt_prefix_is_mask = 1'b0;
			nxt_high_nibble    = 4'd0;
			nxt_type           = 8'd0;
			nxt_length         = 8'd0;
			nxt_bytes_done     = 8'd0;
			nxt_word           = 32'd0;
			nxt_digit_count    = 4'd0;
		end
	end

	// line state registers, updated on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= hmlp_pkg::PH_PREFIX;
			prefix_pos_q     <= 3'd0;
			prefix_is_mask_q <= 1'b0;
			high_nibble_q    <= 4'd0;
			type_q           <= 8'd0;
			length_q         <= 8'd0;
			bytes_done_q     <= 8'd0;
			word_q           <= 32'd0;
			digit_count_q    <= 4'd0;
		end else if (in_acc) begin
			phase_q          <= nxt_phase;
			prefix_pos_q     <= nxt_prefix_pos;
			prefix_is_mask_q <= nxt_prefix_is_mask;
			high_nibble_q    <= nxt_high_nibble;
			type_q           <= nxt_type;
			length_q         <= nxt_length;
			bytes_done_q     <= nxt_bytes_done;
			word_q           <= nxt_word;
			digit_count_q    <= nxt_digit_count;
		end
	end

	// output register: loads a new record, or empties when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (in_acc && res_vld) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && res_vld) begin
			m_kind_q <= res_kind;
			m_data_q <= {res_mask, res_crc, res_value, res_index, res_length, res_type};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_kind_q;

`ifndef ASSERT_OFF
	// a line end always brings the parser back to the line start
	a_line_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_tlast) |=> (phase_q == hmlp_pkg::PH_PREFIX && prefix_pos_q == 3'd0))
		else $error("parser not at line start after line end");

	// payload phase never holds a finished byte count
	a_pay_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == hmlp_pkg::PH_PAY) |-> (bytes_done_q < length_q))
		else $error("payload count reached length without leaving payload phase");

	// word digit counter stays below a full word
	a_word_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == hmlp_pkg::PH_CRC || phase_q == hmlp_pkg::PH_MASK)
		|-> (digit_count_q < 4'(hmlp_pkg::WORD_DIGITS)))
		else $error("word digit count overflow");

	// byte fields take at most two digits
	a_byte_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == hmlp_pkg::PH_TYPE || phase_q == hmlp_pkg::PH_LEN ||
		 phase_q == hmlp_pkg::PH_PAY) |-> (digit_count_q <= 4'd1))
		else $error("byte digit count overflow");
`endif

endmodule

/* bench/line_record_checker.sv */
module line_record_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [95:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		hmlp_pkg::kind_t kind;
		logic [7:0]      msg_type;
		logic [7:0]      msg_length;
		logic [7:0]      byte_idx;
		logic [7:0]      byte_val;
		logic [31:0]     crc;
		logic [31:0]     mask;
	} line_rec_t;

	line_rec_t awaited_records[$];

	// shadow of the line parse state
	hmlp_pkg::phase_t ln_phase;
	logic [2:0]  pfx_pos;
	logic        pfx_mask;
	logic [3:0]  hi_nib;
	logic [7:0]  ty;
	logic [7:0]  len;
	logic [7:0]  done_cnt;
	logic [31:0] word;
	logic [3:0]  digits;

	initial fail_count = 0;

	task automatic report(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report($sformatf("%s got %0h expected %0h", name, got, want));
		end
	endtask

	task automatic line_start();
		ln_phase = hmlp_pkg::PH_PREFIX;
		pfx_pos  = 3'd0;
		pfx_mask = 1'b0;
		hi_nib   = 4'd0;
		ty       = 8'd0;
		len      = 8'd0;
		done_cnt = 8'd0;
		word     = 32'd0;
		digits   = 4'd0;
	endtask

	task automatic parse_char(input logic [7:0] c, input logic eol);
		logic       ok;
		logic       is_hex;
		logic [3:0] nib;
		logic [7:0] b;
		logic       emit;
		line_rec_t  rec;
		emit   = 1'b0;
		rec    = '0;
		ok     = 1'b0;
		is_hex = 1'b1;
		nib    = 4'd0;
		if (c >= "0" && c <= "9") begin
			nib = 4'(c - "0");
		end else if (c >= "a" && c <= "f") begin
			nib = 4'(c - "a" + 8'd10);
		end else if (c >= "A" && c <= "F") begin
			nib = 4'(c - "A" + 8'd10);
		end else begin
			is_hex = 1'b0;
		end

		case (ln_phase)
		hmlp_pkg::PH_PREFIX: begin
			case (pfx_pos)
			3'd0: ok = (c == hmlp_pkg::CH_M);
			3'd1: begin
				ok = (c == hmlp_pkg::CH_E) || (c == hmlp_pkg::CH_A);
				if (ok) pfx_mask = (c == hmlp_pkg::CH_A);
			end
			3'd2: ok = (c == hmlp_pkg::CH_S);
			3'd3: ok = (c == (pfx_mask ? hmlp_pkg::CH_K : hmlp_pkg::CH_S));
			3'd4: ok = (c == hmlp_pkg::CH_EQ);
			default: ok = 1'b0;
			endcase
			if (!ok) begin
				emit     = 1'b1;
				rec.kind = hmlp_pkg::KIND_UNDEF;
				ln_phase = hmlp_pkg::PH_SKIP;
			end else if (pfx_pos == 3'(hmlp_pkg::PREFIX_LAST)) begin
				if (pfx_mask) ln_phase = hmlp_pkg::PH_MASK;
				else ln_phase = hmlp_pkg::PH_TYPE;
				digits = 4'd0;
				word   = 32'd0;
			end else begin
				pfx_pos++;
			end
		end
		hmlp_pkg::PH_TYPE, hmlp_pkg::PH_LEN, hmlp_pkg::PH_PAY, hmlp_pkg::PH_CRC,
		hmlp_pkg::PH_MASK: begin
			if (!is_hex) begin
				emit     = 1'b1;
				rec.kind = hmlp_pkg::KIND_UNDEF;
				ln_phase = hmlp_pkg::PH_SKIP;
			end else if (ln_phase == hmlp_pkg::PH_CRC || ln_phase == hmlp_pkg::PH_MASK) begin
				word = {word[27:0], nib};
				digits++;
				if (digits == 4'(hmlp_pkg::WORD_DIGITS)) begin
					emit = 1'b1;
					if (ln_phase == hmlp_pkg::PH_CRC) begin
						rec.kind       = hmlp_pkg::KIND_MSG_DONE;
						rec.msg_type   = ty;
						rec.msg_length = len;
						rec.crc        = word;
					end else begin
						rec.kind = hmlp_pkg::KIND_MASK;
						rec.mask = word;
					end
					ln_phase = hmlp_pkg::PH_SKIP;
				end
			end else if (digits == 4'd0) begin
				hi_nib = nib;
				digits = 4'd1;
			end else begin
				b      = {hi_nib, nib};
				digits = 4'd0;
				case (ln_phase)
				hmlp_pkg::PH_TYPE: begin
					ty       = b;
					ln_phase = hmlp_pkg::PH_LEN;
				end
				hmlp_pkg::PH_LEN: begin
					len      = b;
					done_cnt = 8'd0;
					word     = 32'd0;
					// zero length skips straight to the crc digits
					if (b != 8'd0) ln_phase = hmlp_pkg::PH_PAY;
					else ln_phase = hmlp_pkg::PH_CRC;
				end
				default: begin
					emit           = 1'b1;
					rec.kind       = hmlp_pkg::KIND_PAYLOAD;
					rec.msg_type   = ty;
					rec.msg_length = len;
					rec.byte_idx   = done_cnt;
					rec.byte_val   = b;
					done_cnt++;
					if (done_cnt == len) begin
						ln_phase = hmlp_pkg::PH_CRC;
						word     = 32'd0;
						digits   = 4'd0;
					end
				end
				endcase
			end
		end
		default: ;
		endcase

		// an unfinished line ends in an undefined record, even over a payload byte
		if (eol) begin
			if (ln_phase != hmlp_pkg::PH_SKIP) begin
				emit     = 1'b1;
				rec      = '0;
				rec.kind = hmlp_pkg::KIND_UNDEF;
			end
			line_start();
		end
		if (emit) awaited_records.push_back(rec);
	endtask

	always @(posedge clk) begin
		line_rec_t want;
		if (!arst_n) begin
			line_start();
			awaited_records.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (awaited_records.size() == 0) begin
					report($sformatf("record kind %0d with nothing expected", m_tuser));
				end else begin
					want = awaited_records.pop_front();
					compare_field("kind", 32'(m_tuser), 32'(want.kind));
					compare_field("msg_type", 32'(m_tdata[7:0]), 32'(want.msg_type));
					compare_field("msg_length", 32'(m_tdata[15:8]), 32'(want.msg_length));
					compare_field("byte_index", 32'(m_tdata[23:16]), 32'(want.byte_idx));
					compare_field("byte_value", 32'(m_tdata[31:24]), 32'(want.byte_val));
					compare_field("crc_value", m_tdata[63:32], want.crc);
					compare_field("mask_value", m_tdata[95:64], want.mask);
				end
			end
			if (s_tvalid && s_tready) parse_char(s_tdata, s_tlast);
		end
		pending <= awaited_records.size();
	end

endmodule

/* bench/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// cycles with no beat on either side before the run is declared hung
	localparam int STALL_LIMIT = 1000;
	// random characters per idling phase
	localparam int PHASE_CHARS = 330;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // char_code[7:0]
	logic        s_tlast;   // line_end
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;   // msg_type, msg_length, byte_index, byte_value,
	                        // crc_value, mask_value
	logic [1:0]  m_tuser;   // kind

	int fail_count;
	int pending;
	int idle_pct;
	int stall_pct;
	int chars_sent;
	int quiet_cycles;

	// characters of the line being built, sent first to last
	logic [7:0] line_chars[$];

	hex_message_line_parser i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	line_record_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// hang detection: nothing accepted on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one character beat, with random idle cycles ahead of it
	task automatic send_char(input logic [7:0] c, input logic eol);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= eol;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_line();
		for (int i = 0; i < line_chars.size(); i++) begin
			send_char(line_chars[i], i == line_chars.size() - 1);
		end
		chars_sent += line_chars.size();
	endtask

	task automatic send_text(input string s);
		line_chars.delete();
		for (int i = 0; i < s.len(); i++) line_chars.push_back(s[i]);
		send_line();
	endtask

	// hex digit in ascii, letters in random case
	function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
		if (nib < 4'd10) return 8'h30 + 8'(nib);
		return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
	endfunction

	task automatic push_hex(input logic [31:0] val, input int n_digits);
		for (int i = n_digits - 1; i >= 0; i--) line_chars.push_back(hex_ascii(val[4*i +: 4]));
	endtask

	task automatic push_prefix(input logic is_mask);
		line_chars.delete();
		line_chars.push_back(hmlp_pkg::CH_M);
		line_chars.push_back(is_mask ? hmlp_pkg::CH_A : hmlp_pkg::CH_E);
		line_chars.push_back(hmlp_pkg::CH_S);
		line_chars.push_back(is_mask ? hmlp_pkg::CH_K : hmlp_pkg::CH_S);
		line_chars.push_back(hmlp_pkg::CH_EQ);
	endtask

	task automatic build_message(input int len);
		push_prefix(1'b0);
		push_hex(32'($urandom_range(255)), 2);
		push_hex(32'(len), 2);
		repeat (len) push_hex(32'($urandom_range(255)), 2);
		push_hex($urandom, 8);
	endtask

	task automatic build_mask();
		push_prefix(1'b1);
		push_hex($urandom, 8);
	endtask

	// mostly short payloads, now and then a long one
	function automatic int pick_length();
		int r;
		r = $urandom_range(199);
		if (r == 0) return $urandom_range(255, 200);
		if (r < 30) return $urandom_range(20, 5);
		return $urandom_range(4);
	endfunction

	task automatic random_line();
		int         r;
		int         pos;
		int         keep;
		logic [7:0] c;
		r = $urandom_range(99);
		if (r < 90) begin
			if ($urandom_range(2) != 0) build_message(pick_length());
			else build_mask();
			if (r < 60) begin
				// well formed, sometimes with junk after the record
				if ($urandom_range(3) == 0) begin
					repeat ($urandom_range(3, 1)) line_chars.push_back(8'($urandom));
				end
			end else if (r < 70) begin
				// line ends before the record is complete
				keep = $urandom_range(line_chars.size() - 1, 1);
				while (line_chars.size() > keep) void'(line_chars.pop_back());
			end else if (r < 80) begin
				// a non-hex character where a digit belongs
				pos = $urandom_range(line_chars.size() - 1, 5);
				do c = 8'($urandom);
				while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
					(c >= "A" && c <= "F"));
				line_chars[pos] = c;
			end else begin
				// broken prefix, often a near miss built from prefix letters
				pos = $urandom_range(4);
				if ($urandom_range(1)) line_chars[pos] = line_chars[$urandom_range(4)];
				else line_chars[pos] = 8'($urandom);
			end
		end else begin
			// plain noise
			line_chars.delete();
			repeat ($urandom_range(8, 1)) line_chars.push_back(8'($urandom));
		end
		send_line();
	endtask

	// hold the sender until every awaited record has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		int idle_tbl[4];
		int stall_tbl[4];
		int target;
		idle_tbl  = '{0, 53, 0, 21};
		stall_tbl = '{0, 0, 53, 21};
		idle_pct   = 0;
		chars_sent = 0;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= 8'd0;
		s_tlast   <= 1'b0;
		m_tready  <= 1'b0;
		stall_pct <= 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lines: extreme characters, early end over a payload byte,
		// bad digit in a mask, message cut after its type
		line_chars.delete();
		line_chars.push_back(8'hff);
		send_line();
		send_text("mess=0001Ff");
		send_text("mask=z");
		line_chars.delete();
		line_chars.push_back(8'h00);
		send_line();
		send_text("mess=00");
		drain();

		// longest payload once, byte index runs up to 254
		build_message(255);
		send_line();

		for (int p = 0; p < 4; p++) begin
			idle_pct  = idle_tbl[p];
			stall_pct <= stall_tbl[p];
			target = chars_sent + PHASE_CHARS;
			while (chars_sent < target) random_line();
			drain();
		end

		// late or extra records still get caught here
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
